// ----- hdl/stp_pkg.sv -----
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types, constants and helper functions of the STUN message parser.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam logic [31:0] COOKIE       = 32'h2112A442;
    localparam logic [31:0] FP_XOR       = 32'h5354554E;
    localparam logic [15:0] GUID_RESET   = 16'hC000;
    localparam int          QUEUE_DEPTH  = 4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HEADER   = 3'd1;
    localparam logic [2:0] ST_COOKIE   = 3'd2;
    localparam logic [2:0] ST_LENGTH   = 3'd3;
    localparam logic [2:0] ST_ATTR     = 3'd4;
    localparam logic [2:0] ST_ORDER    = 3'd5;
    localparam logic [2:0] ST_FPRINT   = 3'd6;
    localparam logic [2:0] ST_OVERRUN  = 3'd7;

    localparam logic [15:0] AT_MAPPED   = 16'h0001;
    localparam logic [15:0] AT_USER     = 16'h0006;
    localparam logic [15:0] AT_INTEG    = 16'h0008;
    localparam logic [15:0] AT_ERROR    = 16'h0009;
    localparam logic [15:0] AT_UNKLIST  = 16'h000A;
    localparam logic [15:0] AT_XMAPPED  = 16'h0020;
    localparam logic [15:0] AT_PRIO     = 16'h0024;
    localparam logic [15:0] AT_USECAND  = 16'h0025;
    localparam logic [15:0] AT_FP       = 16'h8028;
    localparam logic [15:0] AT_ICE_CTLD = 16'h8029;
    localparam logic [15:0] AT_ICE_CTLG = 16'h802A;

    typedef enum logic [3:0] {
        K_UNKNOWN, K_MAPPED, K_XMAPPED, K_USER, K_INTEG, K_ERROR, K_UNKLIST,
        K_PRIO, K_USECAND, K_FP, K_ICE, K_GUID
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_last;
    } t_in_item;

    typedef struct packed {
        logic        record_kind;
        logic [15:0] attr_type;
        logic [15:0] attr_length;
        logic [15:0] port_value;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [63:0] scalar_value;
        logic [2:0]  status;
        logic [1:0]  msg_class;
        logic [11:0] msg_method;
        logic        run_last;
    } t_out_item;

    typedef struct packed {
        logic        attr_v;
        logic [15:0] attr_type;
        logic [15:0] attr_length;
        logic [15:0] port_value;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [63:0] scalar_value;
        logic        end_v;
        logic [2:0]  status;
        logic [1:0]  msg_class;
        logic [11:0] msg_method;
    } t_bundle;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_kind kind_of(input logic [15:0] t, input logic [15:0] guid);
        t_kind k;
        case (t)
            AT_MAPPED:   k = K_MAPPED;
            AT_USER:     k = K_USER;
            AT_INTEG:    k = K_INTEG;
            AT_ERROR:    k = K_ERROR;
            AT_UNKLIST:  k = K_UNKLIST;
            AT_XMAPPED:  k = K_XMAPPED;
            AT_PRIO:     k = K_PRIO;
            AT_USECAND:  k = K_USECAND;
            AT_FP:       k = K_FP;
            AT_ICE_CTLD: k = K_ICE;
            AT_ICE_CTLG: k = K_ICE;
            default:     k = (t == guid) ? K_GUID : K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic length_ok(input t_kind k, input logic [15:0] len);
        logic ok;
        case (k)
            K_MAPPED, K_XMAPPED: ok = (len == 16'd8) || (len == 16'd20);
            K_USER:              ok = (len <= 16'd512);
            K_INTEG:             ok = (len == 16'd20);
            K_ERROR:             ok = (len >= 16'd4) && (len <= 16'd767);
            K_PRIO, K_FP:        ok = (len == 16'd4);
            K_USECAND:           ok = (len == 16'd0);
            K_ICE:               ok = (len == 16'd8);
            K_GUID:              ok = (len == 16'd12);
            default:             ok = 1'b1;
        endcase
        return ok;
    endfunction

    function automatic logic [16:0] extent_of(input logic [15:0] len);
        return 17'd4 + ((17'(len) + 17'd3) & ~17'd3);
    endfunction

endpackage

// ----- hdl/stp_front.sv -----
// ----------------------------------------------------------------------------
// stp_front
// Byte parser: header checks, attribute walk, value decode and running CRC.
// ----------------------------------------------------------------------------
module stp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_wdata,
    input  logic             i_accept,
    input  stp_pkg::t_in_item i_item,
    output logic             o_push,
    output stp_pkg::t_bundle o_bundle
);

    logic [15:0] r_guid;
    logic [15:0] r_pos,       n_pos;
    logic        r_in_body,   n_in_body;
    logic [15:0] r_decl,      n_decl;
    logic [13:0] r_cm,        n_cm;
    logic [7:0]  r_txn [12];
    logic        n_txn_we;
    logic [3:0]  n_txn_idx;
    logic [15:0] r_type,      n_type;
    logic [15:0] r_len,       n_len;
    logic [16:0] r_off,       n_off;
    logic [63:0] r_acc0,      n_acc0;
    logic [63:0] r_acc1,      n_acc1;
    logic [31:0] r_crc,       n_crc;
    logic [31:0] r_crc_start, n_crc_start;
    logic [15:0] r_padded,    n_padded;
    logic        r_integ,     n_integ;
    logic        r_fp,        n_fp;
    logic [2:0]  r_err,       n_err;
    logic [15:0] r_port,      n_port;
    logic [7:0]  r_fam,       n_fam;

    stp_pkg::t_bundle bnd;

    always_comb begin
        logic [7:0]  b;
        logic [15:0] t;
        logic [16:0] v;
        logic [16:0] ix;
        logic [7:0]  key;
        logic [7:0]  bx;
        logic [17:0] need;
        logic [16:0] ext;
        stp_pkg::t_kind k;
        logic        start;

        b = i_item.data_byte;
        n_pos = r_pos; n_in_body = r_in_body; n_decl = r_decl; n_cm = r_cm;
        n_type = r_type; n_len = r_len; n_off = r_off; n_acc0 = r_acc0; n_acc1 = r_acc1;
        n_crc = stp_pkg::crc_byte(r_crc, b);
        n_crc_start = r_crc_start; n_padded = r_padded; n_integ = r_integ; n_fp = r_fp;
        n_err = r_err; n_port = r_port; n_fam = r_fam;
        n_txn_we = 1'b0; n_txn_idx = r_pos[3:0] - 4'd8;
        bnd = '0;
        t = r_acc0[15:0]; v = '0; ix = '0; key = '0; bx = b; need = '0; start = 1'b0;
        ext = '0;
        k = stp_pkg::K_UNKNOWN;

        if (!r_in_body) begin
            if (r_pos < 16'd2) begin
                n_acc0 = {r_acc0[55:0], b};
            end else if (r_pos < 16'd4) begin
                n_decl = {r_decl[7:0], b};
            end else if (r_pos < 16'd8) begin
                n_acc1 = {r_acc1[55:0], b};
            end else begin
                n_txn_we = 1'b1;
            end
            if (r_pos == 16'd3 && r_err == stp_pkg::ST_OK) begin
                if (t[15:14] != 2'b00 || n_decl[1:0] != 2'b00) begin
                    n_err = stp_pkg::ST_HEADER;
                end else begin
                    n_cm = {t[8], t[4], t[13:9], t[7:5], t[3:0]};
                end
            end
            if (r_pos == 16'd7 && r_err == stp_pkg::ST_OK && n_acc1[31:0] != stp_pkg::COOKIE) begin
                n_err = stp_pkg::ST_COOKIE;
            end
            n_pos = r_pos + 16'd1;
            if (n_pos == 16'd20) begin
                n_in_body = 1'b1;
                n_pos = '0;
                n_acc0 = '0;
                n_acc1 = '0;
            end
        end else begin
            if (r_pos != 16'hFFFF) begin
                n_pos = r_pos + 16'd1;
            end
            start = (r_off == '0);
            if (r_err == stp_pkg::ST_OK && !(start && r_padded >= r_decl)) begin
                if (start) begin
                    n_crc_start = r_crc;
                    n_acc0 = '0; n_acc1 = '0; n_type = '0; n_len = '0;
                    n_port = '0; n_fam = '0;
                end
                if (r_off < 17'd2) begin
                    n_type = {n_type[7:0], b};
                end else if (r_off < 17'd4) begin
                    n_len = {n_len[7:0], b};
                end
                k = stp_pkg::kind_of(n_type, r_guid);
                ext = stp_pkg::extent_of(n_len);
                if (r_off == 17'd3) begin
                    need = {2'b00, r_padded} + {1'b0, ext};
                    if (!stp_pkg::length_ok(k, n_len)) begin
                        n_err = stp_pkg::ST_ATTR;
                    end else if (need > {2'b00, r_decl}) begin
                        n_err = stp_pkg::ST_OVERRUN;
                    end
                end else if (r_off >= 17'd4) begin
                    v = r_off - 17'd4;
                    if (v < {1'b0, n_len}) begin
                        case (k)
                            stp_pkg::K_MAPPED, stp_pkg::K_XMAPPED: begin
                                if (v == 17'd1) begin
                                    n_fam = b;
                                    if (!((b == 8'd1 && n_len == 16'd8) ||
                                          (b == 8'd2 && n_len == 16'd20))) begin
                                        n_err = stp_pkg::ST_ATTR;
                                    end
                                end else if (v == 17'd2 || v == 17'd3) begin
                                    n_port = {n_port[7:0], b};
                                end else if (v >= 17'd4) begin
                                    ix = v - 17'd4;
                                    if (ix < 17'd4) begin
                                        key = 8'(stp_pkg::COOKIE >> {~ix[1:0], 3'b000});
                                    end else begin
                                        key = r_txn[4'(ix - 17'd4)];
                                    end
                                    if (k == stp_pkg::K_XMAPPED) begin
                                        bx = b ^ key;
                                    end
                                    if (ix < 17'd8) begin
                                        n_acc0 = {n_acc0[55:0], bx};
                                    end else begin
                                        n_acc1 = {n_acc1[55:0], bx};
                                    end
                                end
                            end
                            stp_pkg::K_ERROR: begin
                                if (v < 17'd4) begin
                                    n_acc1 = {n_acc1[55:0], b};
                                    if (v == 17'd3 && (n_acc1[10:8] < 3'd3 || n_acc1[10:8] > 3'd6 ||
                                                       n_acc1[7:0] > 8'd100)) begin
                                        n_err = stp_pkg::ST_ATTR;
                                    end
                                end
                            end
                            stp_pkg::K_PRIO, stp_pkg::K_FP, stp_pkg::K_ICE: begin
                                if (v < 17'd8) begin
                                    n_acc1 = {n_acc1[55:0], b};
                                end
                            end
                            stp_pkg::K_GUID: begin
                                if (v < 17'd8) begin
                                    n_acc0 = {n_acc0[55:0], b};
                                end else begin
                                    n_acc1 = {n_acc1[55:0], b};
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                n_off = r_off + 17'd1;
                if (n_err == stp_pkg::ST_OK && r_off >= 17'd3 && n_off == ext) begin
                    if (r_fp || (r_integ && k != stp_pkg::K_FP)) begin
                        n_err = stp_pkg::ST_ORDER;
                    end else if (k == stp_pkg::K_FP &&
                                 n_acc1[31:0] != ((~n_crc_start) ^ stp_pkg::FP_XOR)) begin
                        n_err = stp_pkg::ST_FPRINT;
                    end else begin
                        bnd.attr_v      = 1'b1;
                        bnd.attr_type   = n_type;
                        bnd.attr_length = n_len;
                        case (k)
                            stp_pkg::K_MAPPED, stp_pkg::K_XMAPPED: begin
                                bnd.port_value = (k == stp_pkg::K_XMAPPED) ?
                                                 (n_port ^ stp_pkg::COOKIE[31:16]) : n_port;
                                if (n_fam == 8'd1) begin
                                    bnd.addr_low = {32'd0, n_acc0[31:0]};
                                end else begin
                                    bnd.addr_high = n_acc0;
                                    bnd.addr_low  = n_acc1;
                                end
                                bnd.scalar_value = {56'd0, n_fam};
                            end
                            stp_pkg::K_ERROR: begin
                                bnd.scalar_value = 64'(n_acc1[10:8] * 10'd100) + {56'd0, n_acc1[7:0]};
                            end
                            stp_pkg::K_PRIO, stp_pkg::K_FP: begin
                                bnd.scalar_value = {32'd0, n_acc1[31:0]};
                            end
                            stp_pkg::K_ICE: begin
                                bnd.scalar_value = n_acc1;
                            end
                            stp_pkg::K_GUID: begin
                                bnd.addr_high = n_acc0;
                                bnd.addr_low  = {32'd0, n_acc1[31:0]};
                            end
                            default: begin
                            end
                        endcase
                        if (k == stp_pkg::K_INTEG) begin
                            n_integ = 1'b1;
                        end
                        if (k == stp_pkg::K_FP) begin
                            n_fp = 1'b1;
                        end
                        n_padded = r_padded + ext[15:0];
                        n_off = '0;
                    end
                end
            end
        end

        if (i_item.byte_last) begin
            bnd.end_v = 1'b1;
            if (n_err == stp_pkg::ST_HEADER || n_err == stp_pkg::ST_COOKIE) begin
                bnd.status = n_err;
            end else if (!n_in_body || n_pos != n_decl) begin
                bnd.status = stp_pkg::ST_LENGTH;
            end else begin
                bnd.status = n_err;
            end
            bnd.msg_class  = n_cm[13:12];
            bnd.msg_method = n_cm[11:0];
            n_pos = '0; n_in_body = 1'b0; n_decl = '0; n_cm = '0;
            n_type = '0; n_len = '0; n_off = '0; n_acc0 = '0; n_acc1 = '0;
            n_crc = '1; n_crc_start = '0; n_padded = '0; n_integ = 1'b0; n_fp = 1'b0;
            n_err = stp_pkg::ST_OK; n_port = '0; n_fam = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guid <= stp_pkg::GUID_RESET;
        end else if (i_cfg_we) begin
            r_guid <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_in_body <= 1'b0; r_decl <= '0; r_cm <= '0;
            r_type <= '0; r_len <= '0; r_off <= '0; r_acc0 <= '0; r_acc1 <= '0;
            r_crc <= '1; r_crc_start <= '0; r_padded <= '0; r_integ <= 1'b0;
            r_fp <= 1'b0; r_err <= stp_pkg::ST_OK; r_port <= '0; r_fam <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos; r_in_body <= n_in_body; r_decl <= n_decl; r_cm <= n_cm;
            r_type <= n_type; r_len <= n_len; r_off <= n_off; r_acc0 <= n_acc0;
            r_acc1 <= n_acc1; r_crc <= n_crc; r_crc_start <= n_crc_start;
            r_padded <= n_padded; r_integ <= n_integ; r_fp <= n_fp; r_err <= n_err;
            r_port <= n_port; r_fam <= n_fam;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && n_txn_we) begin
            r_txn[n_txn_idx] <= i_item.data_byte;
        end
    end

    assign o_push   = i_accept && (bnd.attr_v || bnd.end_v);
    assign o_bundle = bnd;

endmodule

// ----- hdl/stp_back.sv -----
// ----------------------------------------------------------------------------
// stp_back
// Record queue and output sequencer: splits each entry into one or two records.
// ----------------------------------------------------------------------------
module stp_back #(
    parameter int P_DEPTH = stp_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  stp_pkg::t_bundle  i_bundle,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output stp_pkg::t_out_item o_item
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    stp_pkg::t_bundle r_q [P_DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          r_half, n_half;

    stp_pkg::t_bundle head;
    logic          both;
    logic          take;
    logic          adv;

    assign head    = r_q[r_rd];
    assign both    = head.attr_v && head.end_v;
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(P_DEPTH));
    assign take    = i_pop && !o_empty;
    assign adv     = take && !(both && !r_half);

    always_comb begin
        o_item = '0;
        if (head.attr_v && !r_half) begin
            o_item.record_kind  = 1'b0;
            o_item.attr_type    = head.attr_type;
            o_item.attr_length  = head.attr_length;
            o_item.port_value   = head.port_value;
            o_item.addr_high    = head.addr_high;
            o_item.addr_low     = head.addr_low;
            o_item.scalar_value = head.scalar_value;
            o_item.run_last     = !head.end_v;
        end else begin
            o_item.record_kind = 1'b1;
            o_item.status      = head.status;
            o_item.msg_class   = head.msg_class;
            o_item.msg_method  = head.msg_method;
            o_item.run_last    = 1'b1;
        end
    end

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_half  = r_half;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(P_DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (adv) begin
            n_rd   = (r_rd == AW'(P_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            n_half = 1'b0;
        end else if (take) begin
            n_half = 1'b1;
        end
        n_count = r_count + CW'(i_push) - CW'(adv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_count <= '0; r_half <= 1'b0;
        end else begin
            r_wr <= n_wr; r_rd <= n_rd; r_count <= n_count; r_half <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_bundle;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(P_DEPTH))
        else $error("queue count above depth");

    a_half_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (!o_empty && head.attr_v && head.end_v))
        else $error("second record step without a paired entry");

    a_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && both && !r_half) |=> (r_half && $stable(r_rd)))
        else $error("paired entry not split into two records");

endmodule

// ----- hdl/stun_message_parser.sv -----
// ----------------------------------------------------------------------------
// stun_message_parser
// STUN datagram parser: one byte per cycle in, attribute and end records out.
// The record a byte causes is registered in the record queue, then popped in order.
// Throughput: one byte per cycle; the front stalls only when the record queue
// of P_QUEUE_DEPTH entries is full, a byte closing an attribute and the message
// takes two result pops. Reset clears all parse state and sets the GUID
// prefix code register to 0xC000; the transaction id bytes are not cleared.
// ----------------------------------------------------------------------------
module stun_message_parser #(
    parameter int P_QUEUE_DEPTH = stp_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               push,
    output logic               full,
    input  stp_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output stp_pkg::t_out_item o_item
);

    logic             accept;
    logic             q_push;
    logic             q_full;
    stp_pkg::t_bundle q_bundle;

    assign full   = q_full;
    assign accept = push && !q_full;

    stp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_push      (q_push),
        .o_bundle    (q_bundle)
    );

    stp_back #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_bundle (q_bundle),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_item   (o_item)
    );

endmodule

// ----- verif/tb_stun_message_parser.sv -----
// ----------------------------------------------------------------------------
// tb_stun_message_parser
// Self-checking bench for the STUN message parser. A directed table of header
// bytes comes first, then random datagrams built from valid attribute lists,
// some with broken bytes, missing tails or extra bytes. Every accepted byte
// goes through a software parser that queues the records it should cause, and
// each popped record is compared field by field with the oldest of them.
// The GUID prefix code register is changed between phases.
// ----------------------------------------------------------------------------
module tb_stun_message_parser;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;

    typedef struct {
        logic [7:0] data;
        bit         last;
        int         want_status;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic       push;
    logic       full;
    stp_pkg::t_in_item   i_item;
    logic       empty;
    logic       pop;
    stp_pkg::t_out_item  o_item;

    stun_message_parser i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_item     (o_item)
    );

    stp_pkg::t_out_item pending_records[$];
    logic [7:0]  datagram[$];
    int          mismatches = 0;
    int          popped = 0;
    int          idle_cycles = 0;
    bit          calm = 0;
    bit          sending_done = 0;

    // parser state
    logic [15:0] guid_code;
    logic [15:0] pos;
    bit          body_phase;
    logic [15:0] decl_len;
    logic [13:0] cls_meth;
    logic [7:0]  tid[12];
    logic [15:0] cur_type;
    logic [15:0] cur_len;
    int unsigned cur_off;
    logic [63:0] acc0, acc1;
    logic [31:0] crc_run;
    logic [31:0] crc_start;
    logic [15:0] pad_total;
    bit          seen_integ, seen_fp;
    logic [2:0]  err;
    logic [15:0] hold_port;
    logic [7:0]  hold_family;

    t_row directed[25] = '{
        '{8'hFF, 1, stp_pkg::ST_LENGTH},
        '{8'hC0, 0, -1}, '{8'h00, 0, -1}, '{8'h00, 0, -1}, '{8'h00, 1, stp_pkg::ST_HEADER},
        '{8'h00, 0, -1}, '{8'h01, 0, -1}, '{8'h00, 0, -1}, '{8'h00, 0, -1},
        '{8'h21, 0, -1}, '{8'h12, 0, -1}, '{8'hA4, 0, -1}, '{8'h42, 0, -1},
        '{8'hFF, 0, -1}, '{8'h00, 0, -1}, '{8'hFF, 0, -1}, '{8'h00, 0, -1},
        '{8'hFF, 0, -1}, '{8'h00, 0, -1}, '{8'hFF, 0, -1}, '{8'h00, 0, -1},
        '{8'hFF, 0, -1}, '{8'h00, 0, -1}, '{8'hFF, 0, -1}, '{8'h00, 1, stp_pkg::ST_OK}
    };

    function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

    function automatic stp_pkg::t_kind attr_class(input logic [15:0] t);
        if (t == stp_pkg::AT_MAPPED) return stp_pkg::K_MAPPED;
        if (t == stp_pkg::AT_USER) return stp_pkg::K_USER;
        if (t == stp_pkg::AT_INTEG) return stp_pkg::K_INTEG;
        if (t == stp_pkg::AT_ERROR) return stp_pkg::K_ERROR;
        if (t == stp_pkg::AT_UNKLIST) return stp_pkg::K_UNKLIST;
        if (t == stp_pkg::AT_XMAPPED) return stp_pkg::K_XMAPPED;
        if (t == stp_pkg::AT_PRIO) return stp_pkg::K_PRIO;
        if (t == stp_pkg::AT_USECAND) return stp_pkg::K_USECAND;
        if (t == stp_pkg::AT_FP) return stp_pkg::K_FP;
        if (t == stp_pkg::AT_ICE_CTLD || t == stp_pkg::AT_ICE_CTLG) return stp_pkg::K_ICE;
        return (t == guid_code) ? stp_pkg::K_GUID : stp_pkg::K_UNKNOWN;
    endfunction

    function automatic bit len_fits(input stp_pkg::t_kind k, input int unsigned len);
        case (k)
            stp_pkg::K_MAPPED, stp_pkg::K_XMAPPED: return len == 8 || len == 20;
            stp_pkg::K_USER:              return len <= 512;
            stp_pkg::K_INTEG:             return len == 20;
            stp_pkg::K_ERROR:             return len >= 4 && len <= 767;
            stp_pkg::K_PRIO, stp_pkg::K_FP: return len == 4;
            stp_pkg::K_USECAND:           return len == 0;
            stp_pkg::K_ICE:               return len == 8;
            stp_pkg::K_GUID:              return len == 12;
            default:                      return 1;
        endcase
    endfunction

    function automatic int unsigned padded_size(input int unsigned len);
        return 4 + ((len + 3) & ~32'd3);
    endfunction

    task automatic clear_message();
        pos = 0; body_phase = 0; decl_len = 0; cls_meth = 0;
        foreach (tid[i]) tid[i] = 0;
        cur_type = 0; cur_len = 0; cur_off = 0; acc0 = 0; acc1 = 0;
        crc_run = 32'hFFFFFFFF; crc_start = 0; pad_total = 0;
        seen_integ = 0; seen_fp = 0; err = stp_pkg::ST_OK; hold_port = 0; hold_family = 0;
    endtask

    task automatic header_byte(input logic [7:0] b);
        logic [15:0] t;
        if (pos < 2) acc0 = {acc0[55:0], b};
        else if (pos < 4) decl_len = {decl_len[7:0], b};
        else if (pos < 8) acc1 = {acc1[55:0], b};
        else tid[pos - 8] = b;
        if (pos == 3 && err == stp_pkg::ST_OK) begin
            t = acc0[15:0];
            if (t[15:14] != 0 || decl_len[1:0] != 0) begin
                err = stp_pkg::ST_HEADER;
            end else begin
                cls_meth = {t[8], t[4], t[13:9], t[7:5], t[3:0]};
            end
        end
        if (pos == 7 && err == stp_pkg::ST_OK && acc1[31:0] != stp_pkg::COOKIE)
            err = stp_pkg::ST_COOKIE;
        pos++;
        if (pos == 20) begin
            body_phase = 1; pos = 0; acc0 = 0; acc1 = 0;
        end
    endtask

    task automatic decode_value(input stp_pkg::t_kind k, input int unsigned v,
                                input logic [7:0] b_in);
        logic [7:0]  b;
        logic [7:0]  key;
        int unsigned i;
        b = b_in;
        if (v >= cur_len) return;
        if (k == stp_pkg::K_MAPPED || k == stp_pkg::K_XMAPPED) begin
            if (v == 1) begin
                hold_family = b;
                if (!((b == 1 && cur_len == 8) || (b == 2 && cur_len == 20))) err = stp_pkg::ST_ATTR;
            end else if (v == 2 || v == 3) begin
                hold_port = {hold_port[7:0], b};
            end else if (v >= 4) begin
                i = v - 4;
                if (k == stp_pkg::K_XMAPPED) begin
                    key = (i < 4) ? 8'(stp_pkg::COOKIE >> (24 - 8 * i)) : tid[(i - 4) % 12];
                    b = b ^ key;
                end
                if (i < 8) acc0 = {acc0[55:0], b};
                else acc1 = {acc1[55:0], b};
            end
        end else if (k == stp_pkg::K_ERROR) begin
            if (v < 4) begin
                acc1 = {acc1[55:0], b};
                if (v == 3 && (acc1[10:8] < 3 || acc1[10:8] > 6 || acc1[7:0] > 100))
                    err = stp_pkg::ST_ATTR;
            end
        end else if (k == stp_pkg::K_PRIO || k == stp_pkg::K_FP || k == stp_pkg::K_ICE) begin
            if (v < 8) acc1 = {acc1[55:0], b};
        end else if (k == stp_pkg::K_GUID) begin
            if (v < 8) acc0 = {acc0[55:0], b};
            else acc1 = {acc1[55:0], b};
        end
    endtask

    task automatic close_attr(input stp_pkg::t_kind k, ref stp_pkg::t_out_item recs[$]);
        stp_pkg::t_out_item r;
        r = '0;
        if (seen_fp || (seen_integ && k != stp_pkg::K_FP)) begin
            err = stp_pkg::ST_ORDER;
            return;
        end
        if (k == stp_pkg::K_FP && acc1[31:0] != (~crc_start ^ stp_pkg::FP_XOR)) begin
            err = stp_pkg::ST_FPRINT;
            return;
        end
        case (k)
            stp_pkg::K_MAPPED, stp_pkg::K_XMAPPED: begin
                r.port_value = (k == stp_pkg::K_XMAPPED) ?
                               (hold_port ^ stp_pkg::COOKIE[31:16]) : hold_port;
                if (hold_family == 1) begin
                    r.addr_low = {32'd0, acc0[31:0]};
                end else begin
                    r.addr_high = acc0;
                    r.addr_low = acc1;
                end
                r.scalar_value = 64'(hold_family);
            end
            stp_pkg::K_ERROR:      r.scalar_value = 64'(acc1[10:8]) * 100 + 64'(acc1[7:0]);
            stp_pkg::K_PRIO, stp_pkg::K_FP: r.scalar_value = {32'd0, acc1[31:0]};
            stp_pkg::K_ICE:        r.scalar_value = acc1;
            stp_pkg::K_GUID: begin
                r.addr_high = acc0;
                r.addr_low = {32'd0, acc1[31:0]};
            end
            default: ;
        endcase
        r.attr_type = cur_type;
        r.attr_length = cur_len;
        recs.insert(recs.size(), r);
        if (k == stp_pkg::K_INTEG) seen_integ = 1;
        if (k == stp_pkg::K_FP) seen_fp = 1;
        pad_total = 16'(pad_total + padded_size(cur_len));
        cur_off = 0;
    endtask

    task automatic body_byte(input logic [7:0] b, input logic [31:0] crc_before,
                             ref stp_pkg::t_out_item recs[$]);
        int unsigned    off;
        stp_pkg::t_kind k;
        if (pos < 16'hFFFF) pos++;
        if (err != stp_pkg::ST_OK) return;
        if (cur_off == 0) begin
            if (pad_total >= decl_len) return;
            crc_start = crc_before;
            acc0 = 0; acc1 = 0; cur_type = 0; cur_len = 0; hold_port = 0; hold_family = 0;
        end
        off = cur_off;
        if (off < 2) cur_type = {cur_type[7:0], b};
        else if (off < 4) cur_len = {cur_len[7:0], b};
        k = attr_class(cur_type);
        if (off == 3) begin
            if (!len_fits(k, cur_len)) err = stp_pkg::ST_ATTR;
            else if (int'(pad_total) + padded_size(cur_len) > int'(decl_len))
                err = stp_pkg::ST_OVERRUN;
        end else if (off >= 4) begin
            decode_value(k, off - 4, b);
        end
        cur_off = off + 1;
        if (err != stp_pkg::ST_OK) return;
        if (off >= 3 && cur_off == padded_size(cur_len)) close_attr(k, recs);
    endtask

    task automatic parse_byte(input logic [7:0] b, input bit last, input int want_status);
        stp_pkg::t_out_item recs[$];
        stp_pkg::t_out_item r;
        logic [31:0]        crc_before;
        crc_before = crc_run;
        crc_run = crc_step(crc_run, b);
        if (!body_phase) header_byte(b);
        else body_byte(b, crc_before, recs);
        if (last) begin
            r = '0;
            r.record_kind = 1;
            if (err == stp_pkg::ST_HEADER || err == stp_pkg::ST_COOKIE) r.status = err;
            else if (!body_phase || pos != decl_len) r.status = stp_pkg::ST_LENGTH;
            else r.status = err;
            if (want_status >= 0) r.status = 3'(want_status);
            r.msg_class = cls_meth[13:12];
            r.msg_method = cls_meth[11:0];
            recs.insert(recs.size(), r);
            clear_message();
        end
        if (recs.size() > 0) recs[recs.size() - 1].run_last = 1;
        foreach (recs[i]) pending_records.insert(pending_records.size(), recs[i]);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last, input int want_status);
        push = 1;
        i_item.data_byte = b;
        i_item.byte_last = last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        parse_byte(b, last, want_status);
        @(negedge i_clk);
        if (!calm && $urandom_range(7) == 0) begin
            push = 0;
            repeat ($urandom_range(13, 1)) @(negedge i_clk);
        end
    endtask

    task automatic put8(input logic [7:0] v);
        datagram.insert(datagram.size(), v);
    endtask

    task automatic put16(input logic [15:0] v);
        put8(v[15:8]);
        put8(v[7:0]);
    endtask

    task automatic build_datagram();
        int unsigned na, len, dl, sz, j;
        logic [15:0] types[$];
        int unsigned lens[$];
        logic [15:0] t;
        bit          add_integ, add_fp;
        logic [31:0] c;
        datagram.delete();
        na = $urandom_range(4);
        dl = 0;
        for (int a = 0; a < na; a++) begin
            case ($urandom_range(12))
                0: begin t = stp_pkg::AT_MAPPED; len = $urandom_range(1) ? 8 : 20; end
                1: begin t = stp_pkg::AT_XMAPPED; len = $urandom_range(1) ? 8 : 20; end
                2: begin
                    t = stp_pkg::AT_USER;
                    len = ($urandom_range(40) == 0) ? 512 : $urandom_range(16);
                end
                3: begin
                    t = stp_pkg::AT_ERROR;
                    len = 4 + (($urandom_range(60) == 0) ? 763 : $urandom_range(9));
                end
                4: begin t = stp_pkg::AT_UNKLIST; len = $urandom_range(3) * 2; end
                5: begin t = stp_pkg::AT_PRIO; len = 4; end
                6: begin t = stp_pkg::AT_USECAND; len = 0; end
                7: begin t = stp_pkg::AT_ICE_CTLD; len = 8; end
                8: begin t = stp_pkg::AT_ICE_CTLG; len = 8; end
                9, 10: begin t = guid_code; len = 12; end
                default: begin t = 16'($urandom); len = $urandom_range(9); end
            endcase
            types.insert(types.size(), t);
            lens.insert(lens.size(), len);
            dl += padded_size(len);
        end
        add_integ = $urandom_range(2) == 0;
        add_fp = $urandom_range(1);
        if (add_integ) dl += 24;
        if (add_fp) dl += 8;
        t = 16'($urandom) & 16'h3FFF;
        if ($urandom_range(15) == 0) t[15:14] = 2'($urandom_range(3, 1));
        put16(t);
        put16(16'(dl));
        put16(stp_pkg::COOKIE[31:16]);
        put16(stp_pkg::COOKIE[15:0]);
        repeat (12) put8(8'($urandom));
        foreach (types[a]) begin
            put16(types[a]);
            put16(16'(lens[a]));
            sz = padded_size(lens[a]) - 4;
            for (j = 0; j < sz; j++) begin
                if ((types[a] == stp_pkg::AT_MAPPED || types[a] == stp_pkg::AT_XMAPPED) && j == 1)
                    put8(lens[a] == 8 ? 8'd1 : 8'd2);
                else if (types[a] == stp_pkg::AT_ERROR && j == 2)
                    put8({5'($urandom), 3'($urandom_range(6, 3))});
                else if (types[a] == stp_pkg::AT_ERROR && j == 3)
                    put8(8'($urandom_range(100)));
                else
                    put8(8'($urandom));
            end
        end
        if (add_integ) begin
            put16(stp_pkg::AT_INTEG);
            put16(16'd20);
            repeat (20) put8(8'($urandom));
        end
        if (add_fp) begin
            c = 32'hFFFFFFFF;
            foreach (datagram[i]) c = crc_step(c, datagram[i]);
            c = ~c ^ stp_pkg::FP_XOR;
            put16(stp_pkg::AT_FP);
            put16(16'd4);
            put16(c[31:16]);
            put16(c[15:0]);
        end
        case ($urandom_range(9))
            0: begin
                j = $urandom_range(datagram.size() - 1);
                datagram[j] = datagram[j] ^ (8'd1 << $urandom_range(7));
            end
            1: repeat ($urandom_range(datagram.size() - 1, 1)) void'(datagram.pop_back());
            2: repeat ($urandom_range(6, 1)) put8(8'($urandom));
            3: begin
                datagram.delete();
                repeat ($urandom_range(30, 1)) put8(8'($urandom));
            end
            default: ;
        endcase
    endtask

    task automatic write_guid(input logic [15:0] v);
        while (pending_records.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 0;
        guid_code = v;
    endtask

    function automatic bit differs(input stp_pkg::t_out_item a, input stp_pkg::t_out_item b);
        return a.record_kind !== b.record_kind || a.attr_type !== b.attr_type ||
               a.attr_length !== b.attr_length || a.port_value !== b.port_value ||
               a.addr_high !== b.addr_high || a.addr_low !== b.addr_low ||
               a.scalar_value !== b.scalar_value || a.status !== b.status ||
               a.msg_class !== b.msg_class || a.msg_method !== b.msg_method ||
               a.run_last !== b.run_last;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int unsigned sent;
        logic [15:0] codes[5];
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        push = 0;
        i_item = '0;
        guid_code = stp_pkg::GUID_RESET;
        clear_message();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        foreach (directed[r]) send_byte(directed[r].data, directed[r].last,
                                        directed[r].want_status);
        codes = '{16'hFFFF, 16'h0000, stp_pkg::AT_MAPPED, 16'($urandom), stp_pkg::GUID_RESET};
        sent = 0;
        foreach (codes[p]) begin
            push = 0;
            write_guid(codes[p]);
            while (sent < 190 * (p + 1)) begin
                build_datagram();
                foreach (datagram[i]) send_byte(datagram[i], i == datagram.size() - 1, -1);
                sent += datagram.size();
                if (sent > 800) calm = 1;
            end
        end
        push = 0;
        sending_done = 1;
    end

    initial begin
        int hold;
        int burst;
        bit held_once;
        hold = 0;
        burst = 0;
        held_once = 0;
        pop = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held_once && popped >= 10) begin
                held_once = 1;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                pop = 0;
            end else if (burst > 0) begin
                burst--;
                pop = 0;
            end else if (!calm && $urandom_range(7) == 0) begin
                burst = $urandom_range(13, 1) - 1;
                pop = 0;
            end else begin
                pop = 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            popped <= popped + 1;
            if (pending_records.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected record: %p", o_item);
            end else if (differs(o_item, pending_records[0])) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("record mismatch\n  want %p\n  got  %p", pending_records[0], o_item);
                void'(pending_records.pop_front());
            end else begin
                void'(pending_records.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL stun_message_parser");
            $finish;
        end
    end

    initial begin
        wait (sending_done);
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_records.size() == 0) begin
            $display("PASS stun_message_parser");
        end else begin
            $display("FAIL stun_message_parser");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/stp_pkg.sv
hdl/stp_front.sv
hdl/stp_back.sv
hdl/stun_message_parser.sv
verif/tb_stun_message_parser.sv
